@@ hdl/bitmap_disk_block_allocator_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef BITMAP_DISK_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_DISK_BLOCK_ALLOCATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define BDBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define BDBA_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bdba_pkg.sv @@
`default_nettype none

package bdba_pkg;

   localparam int NUM_BLOCKS = 64;
   localparam int ROW_BITS   = 8;
   localparam int ID_WIDTH   = 8;

   localparam int NUM_ROWS = NUM_BLOCKS / ROW_BITS;
   localparam int IDX_W    = $clog2(NUM_BLOCKS);
   localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int COL_W    = $clog2(ROW_BITS);
   localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);

   // Field widths of the request and response channels.
   localparam int CMD_W       = 1;
   localparam int FILE_ID_W   = 8;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;
   localparam int ROW_FIELD_W = 3;
   localparam int REC_W       = 2;
   localparam int BIT_W       = 3;

   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic                used;
      logic [ID_WIDTH-1:0] owner;
   } cell_data_type;

   typedef struct packed {
      logic                shift;
      logic                check;
      logic [ID_WIDTH-1:0] id;
   } ring_ctl_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic                   has_block;
      logic [ROW_FIELD_W-1:0] block_row;
      logic                   track;
      logic [REC_W-1:0]       record;
      logic [BIT_W-1:0]       bit_index;
      logic                   last;
   } rsp_fields_type;

   // Builds one response; position fields are masked to their field widths.
   function automatic rsp_fields_type make_rsp(input logic [STATUS_W-1:0] st,
                                               input logic blk,
                                               input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col,
                                               input logic last);
      logic [ROW_W+2:0] r_ext;
      logic [COL_W+2:0] c_ext;
      rsp_fields_type   r;
      r_ext       = {3'b000, row};
      c_ext       = {3'b000, col};
      r.status    = st;
      r.has_block = blk;
      r.block_row = blk ? r_ext[2:0] : '0;
      r.track     = blk ? c_ext[2] : 1'b0;
      r.record    = blk ? c_ext[1:0] : '0;
      r.bit_index = blk ? c_ext[2:0] : '0;
      r.last      = last;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/bdba_req_if.sv @@
`default_nettype none

interface bdba_req_if import bdba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [FILE_ID_W-1:0] file_id;
   logic [COUNT_W-1:0]   block_count;

   modport source (output valid, output cmd, output file_id, output block_count,
                   input ready);
   modport sink (input valid, input cmd, input file_id, input block_count,
                 output ready);
endinterface

`default_nettype wire

@@ hdl/bdba_rsp_if.sv @@
`default_nettype none

interface bdba_rsp_if import bdba_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic                   has_block;
   logic [ROW_FIELD_W-1:0] block_row;
   logic                   track;
   logic [REC_W-1:0]       record;
   logic [BIT_W-1:0]       bit_index;
   logic                   last;

   modport source (output valid, output status, output has_block, output block_row,
                   output track, output record, output bit_index, output last,
                   input ready);
   modport sink (input valid, input status, input has_block, input block_row,
                 input track, input record, input bit_index, input last,
                 output ready);
endinterface

`default_nettype wire

@@ hdl/bitmap_disk_block_allocator.sv @@
// First-fit disk block allocator over a 64-block bitmap (8 rows of 8 columns).
// Each block's used bit and owner id sit in a ring of 64 cells that rotates by
// one place per cycle, unless a response stall holds it, past a single head,
// where blocks are taken or freed. A request is taken only when the block is
// idle. Each passes an id-match check and a decision; one that reaches the scan
// waits out one full turn of the ring (and a release a finish state) before the
// next acceptance, while one answered by status alone (duplicate id, no space,
// zero blocks, id not found) goes to a status state. One response per block, in
// row-major order, the status riding on the response marked last. After reset
// every block is free.
`default_nettype none

module bitmap_disk_block_allocator import bdba_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bdba_req_if.sink   req_ch,
   bdba_rsp_if.source rsp_ch
);

   // Entry NUM_BLOCKS is the write-back from the head into the tail cell.
   cell_data_type         ring_data [NUM_BLOCKS+1];
   logic [NUM_BLOCKS-1:0] match;
   ring_ctl_type          ring_ctl;

   for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
      bdba_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ring_ctl),
         .nxt   (ring_data[i+1]),
         .data  (ring_data[i]),
         .match (match[i])
      );
   end

   bdba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .head     (ring_data[0]),
      .match    (match),
      .tail     (ring_data[NUM_BLOCKS]),
      .ring_ctl (ring_ctl)
   );

endmodule

`default_nettype wire

@@ hdl/bdba_cell.sv @@
`default_nettype none

module bdba_cell import bdba_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ring_ctl_type  ctl,
   input  cell_data_type nxt,
   output cell_data_type data,
   output logic          match
);

   logic                used_ff, used_in;
   logic [ID_WIDTH-1:0] owner_ff, owner_in;
   logic                match_ff, match_in;

   always_comb begin
      used_in  = ctl.shift ? nxt.used : used_ff;
      owner_in = ctl.shift ? nxt.owner : owner_ff;
      match_in = ctl.check ? (used_ff && (owner_ff == ctl.id)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         match_ff <= match_in;
      end
   end

   // The owner id means nothing while the used bit is clear.
   always_ff @(posedge clock) begin
      owner_ff <= owner_in;
   end

   assign data.used  = used_ff;
   assign data.owner = owner_ff;
   assign match      = match_ff;

endmodule

`default_nettype wire

@@ hdl/bdba_ctrl.sv @@
`default_nettype none

module bdba_ctrl import bdba_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bdba_req_if.sink               req_ch,
   bdba_rsp_if.source             rsp_ch,
   input  cell_data_type          head,
   input  logic [NUM_BLOCKS-1:0]  match,
   output cell_data_type          tail,
   output ring_ctl_type           ring_ctl
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_STATUS = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [COUNT_W-1:0]  remain_ff, remain_in;
   logic [CNT_W-1:0]    free_ff, free_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ROW_W-1:0]    pend_row_ff, pend_row_in;
   logic [COL_W-1:0]    pend_col_ff, pend_col_in;
   logic                out_valid_ff, out_valid_in;
   rsp_fields_type      out_ff, out_in;

   logic                   slot_free;
   logic                   step;
   logic                   hit_alloc;
   logic                   hit_rel;
   logic                   any_match;
   logic                   load;
   logic [ID_WIDTH+FILE_ID_W-1:0] id_ext;
   logic [CMP_W-1:0]       want_cmp;
   logic [CMP_W-1:0]       free_cmp;

   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign step      = (state_ff == S_SCAN) && slot_free;
   assign hit_alloc = (cmd_ff == CMD_ALLOC) && (remain_ff != '0) && !head.used;
   assign hit_rel   = (cmd_ff == CMD_RELEASE) && head.used && (head.owner == id_ff);
   assign any_match = |match;
   assign id_ext    = {{ID_WIDTH{1'b0}}, req_ch.file_id};
   assign want_cmp  = CMP_W'(remain_ff);
   assign free_cmp  = CMP_W'(free_ff);

   // The head cell's entry goes back into the tail cell, updated on a hit.
   always_comb begin
      tail = head;
      if (step && hit_alloc) begin
         tail.used  = 1'b1;
         tail.owner = id_ff;
      end else if (step && hit_rel) begin
         tail.used = 1'b0;
      end
   end

   assign ring_ctl.shift = step;
   assign ring_ctl.check = (state_ff == S_CHECK);
   assign ring_ctl.id    = id_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      remain_in     = remain_ff;
      free_in       = free_ff;
      status_in     = status_ff;
      pos_in        = pos_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      out_in        = out_ff;
      load          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in    = req_ch.cmd;
               id_in     = id_ext[ID_WIDTH-1:0];
               remain_in = req_ch.block_count;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            pos_in        = '0;
            row_in        = '0;
            col_in        = '0;
            pend_valid_in = 1'b0;
            status_in     = ST_OK;
            state_in      = S_SCAN;
            if (cmd_ff == CMD_ALLOC) begin
               if (any_match) begin
                  status_in = ST_DUP;
                  state_in  = S_STATUS;
               end else if (want_cmp > free_cmp) begin
                  status_in = ST_NOSPACE;
                  state_in  = S_STATUS;
               end else if (remain_ff == '0) begin
                  state_in = S_STATUS;
               end
            end else if (!any_match) begin
               status_in = ST_NOTFOUND;
               state_in  = S_STATUS;
            end
         end
         S_SCAN: begin
            if (step) begin
               if (hit_alloc) begin
                  load      = 1'b1;
                  out_in    = make_rsp(ST_OK, 1'b1, row_ff, col_ff,
                                       remain_ff == COUNT_W'(1));
                  remain_in = remain_ff - COUNT_W'(1);
                  free_in   = free_ff - CNT_W'(1);
               end
               if (hit_rel) begin
                  // A freed block is held back one hit so that the final one
                  // can carry the last flag.
                  if (pend_valid_ff) begin
                     load   = 1'b1;
                     out_in = make_rsp(ST_OK, 1'b1, pend_row_ff, pend_col_ff, 1'b0);
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = row_ff;
                  pend_col_in   = col_ff;
                  free_in       = free_ff + CNT_W'(1);
               end
               pos_in = pos_ff + IDX_W'(1);
               if (col_ff == COL_W'(ROW_BITS - 1)) begin
                  col_in = '0;
                  row_in = row_ff + ROW_W'(1);
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               if (pos_ff == IDX_W'(NUM_BLOCKS - 1)) begin
                  state_in = (cmd_ff == CMD_ALLOC) ? S_IDLE : S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               load     = 1'b1;
               out_in   = make_rsp(ST_OK, 1'b1, pend_row_ff, pend_col_ff, 1'b1);
               state_in = S_IDLE;
            end
         end
         S_STATUS: begin
            if (slot_free) begin
               load     = 1'b1;
               out_in   = make_rsp(status_ff, 1'b0, '0, '0, 1'b1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_ff       <= CNT_W'(NUM_BLOCKS);
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_ff       <= free_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      remain_ff   <= remain_in;
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      out_ff      <= out_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.status    = out_ff.status;
   assign rsp_ch.has_block = out_ff.has_block;
   assign rsp_ch.block_row = out_ff.block_row;
   assign rsp_ch.track     = out_ff.track;
   assign rsp_ch.record    = out_ff.record;
   assign rsp_ch.bit_index = out_ff.bit_index;
   assign rsp_ch.last      = out_ff.last;

endmodule

`default_nettype wire

@@ hdl/bdba_checker.sv @@
`default_nettype none
`include "bitmap_disk_block_allocator_defines.svh"

module bdba_checker import bdba_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    status,
   input logic                   has_block,
   input logic [ROW_FIELD_W-1:0] block_row,
   input logic                   track,
   input logic [REC_W-1:0]       record,
   input logic [BIT_W-1:0]       bit_index,
   input logic                   last
);

   `BDBA_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")

   `BDBA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(has_block) && $stable(block_row) && $stable(track) && $stable(record) && $stable(bit_index) && $stable(last), "stalled response changed")

   `BDBA_ASSERT(a_err_last, clock, reset, rsp_valid && status != ST_OK |-> last && !has_block, "error status on a block response")

   `BDBA_ASSERT(a_nob_last, clock, reset, rsp_valid && !has_block |-> last, "status-only response not marked last")

   `BDBA_ASSERT(a_one_req, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")

endmodule

bind bitmap_disk_block_allocator bdba_checker u_bdba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .status    (rsp_ch.status),
   .has_block (rsp_ch.has_block),
   .block_row (rsp_ch.block_row),
   .track     (rsp_ch.track),
   .record    (rsp_ch.record),
   .bit_index (rsp_ch.bit_index),
   .last      (rsp_ch.last)
);

`default_nettype wire

@@ verif/bitmap_disk_block_allocator_test.sv @@
`default_nettype none

module bitmap_disk_block_allocator_test import bdba_pkg::*; ();

   // Worst run: about 470 requests, each a full scan of the ring plus up to 64
   // responses that may each wait out a stall.
   localparam int CYCLE_LIMIT     = 4_000_000;
   localparam int DRAIN_CYCLES    = 150;
   localparam int RANDOM_REQUESTS = 450;
   localparam int POOL_SIZE       = 16;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [FILE_ID_W-1:0] file_id;
      logic [COUNT_W-1:0]   block_count;
   } request_type;

   logic clock;
   logic reset;

   bdba_req_if req_ch ();
   bdba_rsp_if rsp_ch ();

   bitmap_disk_block_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   request_type    request_q[$];
   rsp_fields_type owed_rsp[$];
   request_type    next_req;
   request_type    seen_req;
   rsp_fields_type got_rsp;
   rsp_fields_type due_rsp;

   int unsigned total_requests;
   int unsigned accepted_requests;
   int unsigned error_count;
   int unsigned cycle_count;
   logic        req_taken;

   // Predicted contents of the bitmap.
   logic                blk_used  [NUM_BLOCKS];
   logic [ID_WIDTH-1:0] blk_owner [NUM_BLOCKS];

   // Rough per-id block counts, used only to steer stimulus toward legal sequences.
   int unsigned held_blocks [256];
   int unsigned free_blocks;
   logic [7:0]  id_pool [POOL_SIZE];

   int unsigned req_gap;
   int unsigned req_quiet;
   int unsigned rsp_stall;
   int unsigned rsp_quiet;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void owe(logic [STATUS_W-1:0] st, logic blk, int idx, logic last);
      rsp_fields_type r;
      r.status    = st;
      r.has_block = blk;
      r.block_row = blk ? 3'(idx / ROW_BITS) : '0;
      r.track     = blk ? 1'((idx % ROW_BITS) / 4) : 1'b0;
      r.record    = blk ? 2'((idx % ROW_BITS) % 4) : '0;
      r.bit_index = blk ? 3'(idx % ROW_BITS) : '0;
      r.last      = last;
      owed_rsp.push_back(r);
   endfunction

   function automatic void allocate_or_release(request_type rq);
      int  busy;
      int  want;
      logic dup;
      int  hits[$];
      busy = 0;
      dup  = 1'b0;
      want = int'(rq.block_count);
      if (rq.cmd == CMD_ALLOC) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (blk_used[i]) begin
               busy++;
               if (blk_owner[i] == rq.file_id) dup = 1'b1;
            end
         end
         if (dup) begin
            owe(ST_DUP, 1'b0, 0, 1'b1);
         end else if (NUM_BLOCKS - busy < want) begin
            owe(ST_NOSPACE, 1'b0, 0, 1'b1);
         end else if (want == 0) begin
            owe(ST_OK, 1'b0, 0, 1'b1);
         end else begin
            for (int i = 0; i < NUM_BLOCKS && want > 0; i++) begin
               if (!blk_used[i]) begin
                  blk_used[i]  = 1'b1;
                  blk_owner[i] = rq.file_id;
                  want--;
                  owe(ST_OK, 1'b1, i, want == 0);
               end
            end
         end
      end else begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (blk_used[i] && blk_owner[i] == rq.file_id) begin
               blk_used[i] = 1'b0;
               hits.push_back(i);
            end
         end
         if (hits.size() == 0) begin
            owe(ST_NOTFOUND, 1'b0, 0, 1'b1);
         end else begin
            foreach (hits[k]) owe(ST_OK, 1'b1, hits[k], k == hits.size() - 1);
         end
      end
   endfunction

   function automatic void queue_request(logic [CMD_W-1:0] op, int id, int cnt);
      request_q.push_back('{cmd: op, file_id: 8'(id), block_count: 7'(cnt)});
      total_requests++;
      if (op == CMD_ALLOC) begin
         if (held_blocks[id] == 0 && cnt > 0 && cnt <= free_blocks) begin
            held_blocks[id] = cnt;
            free_blocks -= cnt;
         end
      end else begin
         free_blocks += held_blocks[id];
         held_blocks[id] = 0;
      end
   endfunction

   function automatic int pick_pool_id(logic want_held);
      int id;
      for (int t = 0; t < 12; t++) begin
         id = int'(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
         if ((held_blocks[id] != 0) == want_held) return id;
      end
      return -1;
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic void check_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
      if (exp_v !== got_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
      end
   endfunction

   // Request driver: presents queued requests at the falling edge, with random gaps.
   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if (req_quiet > 0) req_quiet--;
         else if ($urandom_range(0, 199) == 0) req_quiet = $urandom_range(30, 120);
         if (!(req_ch.valid && !req_taken)) begin
            if (req_ch.valid && req_quiet == 0) req_gap = idle_length();
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (request_q.size() != 0) begin
               next_req = request_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.cmd         <= next_req.cmd;
               req_ch.file_id     <= next_req.file_id;
               req_ch.block_count <= next_req.block_count;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_quiet > 0) begin
            rsp_quiet--;
            rsp_ch.ready <= 1'b1;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 299) == 0) begin
            rsp_quiet = $urandom_range(30, 150);
            rsp_ch.ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall = idle_length();
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: predicts on every accepted request, then checks any accepted response.
   always @(posedge clock) begin
      if (reset !== 1'b0) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            seen_req.cmd         = req_ch.cmd;
            seen_req.file_id     = req_ch.file_id;
            seen_req.block_count = req_ch.block_count;
            allocate_or_release(seen_req);
            accepted_requests++;
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got_rsp.status    = rsp_ch.status;
            got_rsp.has_block = rsp_ch.has_block;
            got_rsp.block_row = rsp_ch.block_row;
            got_rsp.track     = rsp_ch.track;
            got_rsp.record    = rsp_ch.record;
            got_rsp.bit_index = rsp_ch.bit_index;
            got_rsp.last      = rsp_ch.last;
            if (owed_rsp.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %p", $time, got_rsp);
            end else begin
               due_rsp = owed_rsp.pop_front();
               check_field("status", 8'(due_rsp.status), 8'(got_rsp.status));
               check_field("has_block", 8'(due_rsp.has_block), 8'(got_rsp.has_block));
               check_field("block_row", 8'(due_rsp.block_row), 8'(got_rsp.block_row));
               check_field("track", 8'(due_rsp.track), 8'(got_rsp.track));
               check_field("record", 8'(due_rsp.record), 8'(got_rsp.record));
               check_field("bit_index", 8'(due_rsp.bit_index), 8'(got_rsp.bit_index));
               check_field("last", 8'(due_rsp.last), 8'(got_rsp.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int roll;
      int id;
      int cnt;
      int unsigned queued_then;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_ALLOC;
      req_ch.file_id     = '0;
      req_ch.block_count = '0;
      rsp_ch.ready       = 1'b0;
      req_taken          = 1'b0;
      cycle_count        = 0;
      total_requests     = 0;
      accepted_requests  = 0;
      error_count        = 0;
      req_gap            = 0;
      req_quiet          = 0;
      rsp_stall          = 0;
      rsp_quiet          = 0;
      free_blocks        = NUM_BLOCKS;
      foreach (blk_used[i]) begin
         blk_used[i]  = 1'b0;
         blk_owner[i] = '0;
      end
      foreach (held_blocks[i]) held_blocks[i] = 0;
      foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(0, 255));

      // Directed: empty map, full map, every status, holes refilled first-fit.
      queue_request(CMD_ALLOC, 'h00, 0);
      queue_request(CMD_RELEASE, 'h00, 0);
      queue_request(CMD_ALLOC, 'hFF, 64);
      queue_request(CMD_ALLOC, 'h01, 1);
      queue_request(CMD_ALLOC, 'h01, 0);
      queue_request(CMD_ALLOC, 'hFF, 0);
      queue_request(CMD_RELEASE, 'hFF, 127);
      queue_request(CMD_ALLOC, 'h00, 127);
      queue_request(CMD_ALLOC, 'hAA, 65);
      queue_request(CMD_ALLOC, 'h55, 3);
      queue_request(CMD_ALLOC, 'hAA, 5);
      queue_request(CMD_ALLOC, 'h01, 2);
      queue_request(CMD_RELEASE, 'hAA, 0);
      queue_request(CMD_ALLOC, 'h80, 7);
      queue_request(CMD_ALLOC, 'h55, 1);
      queue_request(CMD_RELEASE, 'h55, 0);
      queue_request(CMD_RELEASE, 'h01, 0);
      queue_request(CMD_RELEASE, 'h80, 0);
      queue_request(CMD_RELEASE, 'h80, 0);
      queue_request(CMD_ALLOC, 'h7F, 64);
      queue_request(CMD_RELEASE, 'h7F, 0);

      // Random: mostly legal allocate/release traffic on a small id pool, plus noise.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         roll        = $urandom_range(0, 99);
         queued_then = total_requests;
         if (roll < 55) begin
            id = pick_pool_id(1'b0);
            if (id >= 0 && free_blocks > 0) begin
               if ($urandom_range(0, 9) == 0) cnt = free_blocks;
               else if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, free_blocks);
               else cnt = $urandom_range(1, free_blocks < 6 ? free_blocks : 6);
               queue_request(CMD_ALLOC, id, cnt);
            end
         end else if (roll < 80) begin
            id = pick_pool_id(1'b1);
            if (id >= 0) queue_request(CMD_RELEASE, id, $urandom_range(0, 127));
         end else if (roll < 85) begin
            id = pick_pool_id(1'b1);
            if (id >= 0) queue_request(CMD_ALLOC, id, $urandom_range(0, 127));
         end else if (roll < 90) begin
            id = pick_pool_id(1'b0);
            if (id >= 0) queue_request(CMD_ALLOC, id, $urandom_range(free_blocks + 1, 127));
         end else if (roll < 94) begin
            queue_request(CMD_ALLOC, $urandom_range(0, 255), 0);
         end else begin
            queue_request(CMD_W'($urandom_range(0, 1)), $urandom_range(0, 255),
                          $urandom_range(0, 127));
         end
         if (total_requests == queued_then)
            queue_request(CMD_RELEASE, int'(id_pool[$urandom_range(0, POOL_SIZE - 1)]), 0);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_requests < total_requests || owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
